// ----- rtl/iir_fourth_order_multichannel_assert.svh -----
// assertion macros shared by the checker
`ifndef IIR_FOURTH_ORDER_MULTICHANNEL_ASSERT_SVH
`define IIR_FOURTH_ORDER_MULTICHANNEL_ASSERT_SVH

// consequent checked in the same cycle
`define IIRFO_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("iirfo check failed");

// consequent checked in the next cycle
`define IIRFO_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("iirfo check failed");

`endif

// ----- rtl/iirfo_pkg.sv -----
// shared constants, codes and stage types of the multichannel fourth-order iir filter
`timescale 1ns / 1ps
`default_nettype none

package iirfo_pkg;

   localparam int CHANNELS    = 6;
   localparam int SAMPLE_BITS = 16;
   localparam int TAPS        = 4;
   localparam int COEFS       = 7;
   localparam int COEF_W      = 16;
   localparam int FRAC_BITS   = 14;
   localparam int CH_W        = 3;
   localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int OP_W        = SAMPLE_BITS + 1;
   localparam int PROD_W      = COEF_W + OP_W;
   localparam int ACC_W       = SAMPLE_BITS + 20;
   localparam int Q_W         = ACC_W - FRAC_BITS;
   localparam int CSR_IDX_W   = 3;
   localparam int SAMPLE_MAX  = 2 ** (SAMPLE_BITS - 1) - 1;

   typedef enum logic {
      ACT_FILTER = 1'b0,
      ACT_CLEAR  = 1'b1
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_B_OUTER  = 3'd0,
      CSR_B_INNER  = 3'd1,
      CSR_B_CENTER = 3'd2,
      CSR_A_FIRST  = 3'd3,
      CSR_A_SECOND = 3'd4,
      CSR_A_THIRD  = 3'd5,
      CSR_A_FOURTH = 3'd6
   } csr_index_type;

   typedef logic signed [COEF_W-1:0] coef_type;

   localparam coef_type COEF_RESET [COEFS] = '{
      16'sd763, 16'sd3053, 16'sd4579, -16'sd12814, 16'sd11141, -16'sd2993, 16'sd493
   };

   typedef struct packed {
      logic                         valid;
      logic [CH_W-1:0]              channel;
      logic signed [ACC_W-1:0]      acc;
      logic [COEFS-1:0][OP_W-1:0]   ops;
   } stage_type;

   typedef struct packed {
      logic                         valid;
      logic [CH_W-1:0]              channel;
      logic [SAMPLE_BITS-1:0]       value;
   } wb_type;

endpackage

`default_nettype wire

// ----- rtl/iirfo_cell.sv -----
// one multiply-accumulate cell of the tap chain
`timescale 1ns / 1ps
`default_nettype none

module iirfo_cell import iirfo_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      enable,
   input  wire coef_type  coef,
   input  wire stage_type stage_in,
   output stage_type      stage_out
);

   stage_type                stage_ff;
   stage_type                stage_in_next;
   logic signed [PROD_W-1:0] prod;

   always_comb begin
      prod          = coef * $signed(stage_in.ops[0]);
      stage_in_next = stage_in;
      stage_in_next.acc = stage_in.acc + ACC_W'(prod);
      // next cell takes the following operand
      stage_in_next.ops = stage_in.ops >> OP_W;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff <= stage_in_next;
      end
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

// ----- rtl/iirfo_front.sv -----
// channel history bank, busy tracking and operand stage feeding the tap chain
`timescale 1ns / 1ps
`default_nettype none

module iirfo_front import iirfo_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   enable,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_action,
   input  wire logic [CH_W-1:0]        req_channel,
   input  wire logic [SAMPLE_BITS-1:0] req_sample,
   input  wire wb_type                 wb,
   output stage_type                   stage_out
);

   logic [TAPS-1:0][SAMPLE_BITS-1:0] xh_ff [CHANNELS];
   logic [TAPS-1:0][SAMPLE_BITS-1:0] xh_in [CHANNELS];
   logic [TAPS-1:0][SAMPLE_BITS-1:0] yh_ff [CHANNELS];
   logic [TAPS-1:0][SAMPLE_BITS-1:0] yh_in [CHANNELS];
   logic [CHANNELS-1:0]              busy_ff;
   logic [CHANNELS-1:0]              busy_in;
   stage_type                        stage_ff;
   stage_type                        stage_in;
   logic                             in_range;
   logic                             accept;
   logic [CH_IDX_W-1:0]              idx;
   logic [CH_IDX_W-1:0]              wb_idx;

   function automatic logic signed [OP_W-1:0] sx(input logic [SAMPLE_BITS-1:0] v);
      return {v[SAMPLE_BITS-1], v};
   endfunction

   assign idx       = req_channel[CH_IDX_W-1:0];
   assign wb_idx    = wb.channel[CH_IDX_W-1:0];
   assign in_range  = int'(req_channel) < CHANNELS;
   assign req_ready = enable && !(in_range && busy_ff[idx]);
   assign accept    = req_valid && req_ready;

   always_comb begin
      xh_in   = xh_ff;
      yh_in   = yh_ff;
      busy_in = busy_ff;
      if (wb.valid) begin
         yh_in[wb_idx]   = {yh_ff[wb_idx][TAPS-2:0], wb.value};
         busy_in[wb_idx] = 1'b0;
      end
      if (accept && in_range) begin
         if (req_action == ACT_CLEAR) begin
            xh_in[idx] = '0;
            yh_in[idx] = '0;
         end else begin
            xh_in[idx]   = {xh_ff[idx][TAPS-2:0], req_sample};
            busy_in[idx] = 1'b1;
         end
      end
   end

   // symmetric numerator folded, feedback operands negated
   always_comb begin
      stage_in.valid   = accept && in_range && (req_action == ACT_FILTER);
      stage_in.channel = req_channel;
      stage_in.acc     = '0;
      stage_in.ops[0]  = sx(req_sample) + sx(xh_ff[idx][3]);
      stage_in.ops[1]  = sx(xh_ff[idx][0]) + sx(xh_ff[idx][2]);
      stage_in.ops[2]  = sx(xh_ff[idx][1]);
      stage_in.ops[3]  = -sx(yh_ff[idx][0]);
      stage_in.ops[4]  = -sx(yh_ff[idx][1]);
      stage_in.ops[5]  = -sx(yh_ff[idx][2]);
      stage_in.ops[6]  = -sx(yh_ff[idx][3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            xh_ff[c] <= '0;
            yh_ff[c] <= '0;
         end
         busy_ff        <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         xh_ff   <= xh_in;
         yh_ff   <= yh_in;
         busy_ff <= busy_in;
         if (enable) begin
            stage_ff <= stage_in;
         end
      end
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

// ----- rtl/iir_fourth_order_multichannel.sv -----
// top level of the six-channel fourth-order direct-form-i iir low-pass filter
//
//   port group   direction   handshake            payload
//   req_         in          req_valid/req_ready  action, channel, sample
//   rsp_         out         rsp_valid/rsp_ready  channel_out, filtered, saturated
//   csr_         in          csr_write_en         index, data (coefficients)
//
// a filter item passes one operand stage, seven multiply-accumulate cells in a chain
// and one round and saturate stage before it reaches rsp_valid.
// items of different channels enter one per cycle unless rsp_ stalls; an item for a
// channel with an item still in the chain waits until that result is loaded.
// reset clears all histories at once; clear items and unknown channels give no item.
// a held result on rsp_ stalls the whole chain and drops req_ready.
`timescale 1ns / 1ps
`default_nettype none

module iir_fourth_order_multichannel import iirfo_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_action,
   input  wire logic [CH_W-1:0]        req_channel,
   input  wire logic [SAMPLE_BITS-1:0] req_sample,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [CH_W-1:0]             rsp_channel_out,
   output logic [SAMPLE_BITS-1:0]      rsp_filtered,
   output logic                        rsp_saturated,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [COEF_W-1:0]      csr_data
);

   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(SAMPLE_MAX);
   localparam logic signed [Q_W-1:0] Q_MIN = -Q_MAX - Q_W'(1);
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (FRAC_BITS - 1));

   coef_type                 coef_ff [COEFS];
   coef_type                 coef_in [COEFS];
   stage_type                chain [COEFS+1];
   wb_type                   wb;
   logic                     enable;
   logic signed [ACC_W-1:0]  rounded;
   logic signed [Q_W-1:0]    q;
   logic [SAMPLE_BITS-1:0]   y;
   logic                     sat;

   logic                     rsp_valid_ff;
   logic [CH_W-1:0]          rsp_channel_ff;
   logic [SAMPLE_BITS-1:0]   rsp_filtered_ff;
   logic                     rsp_saturated_ff;

   always_comb begin
      coef_in = coef_ff;
      if (csr_write_en && csr_index <= CSR_A_FOURTH) begin
         coef_in[csr_index] = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEF_RESET;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign enable = !rsp_valid_ff || rsp_ready;

   iirfo_front u_front (
      .clock       (clock),
      .reset       (reset),
      .enable      (enable),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_action  (req_action),
      .req_channel (req_channel),
      .req_sample  (req_sample),
      .wb          (wb),
      .stage_out   (chain[0])
   );

   for (genvar g = 0; g < COEFS; g++) begin : g_cell
      iirfo_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .coef      (coef_ff[g]),
         .stage_in  (chain[g]),
         .stage_out (chain[g+1])
      );
   end

   // round half up, then clip
   always_comb begin
      rounded = chain[COEFS].acc + ROUND_HALF;
      q       = rounded[ACC_W-1:FRAC_BITS];
      sat     = 1'b1;
      if (q > Q_MAX) begin
         y = Q_MAX[SAMPLE_BITS-1:0];
      end else if (q < Q_MIN) begin
         y = Q_MIN[SAMPLE_BITS-1:0];
      end else begin
         y   = q[SAMPLE_BITS-1:0];
         sat = 1'b0;
      end
   end

   always_comb begin
      wb.valid   = enable && chain[COEFS].valid;
      wb.channel = chain[COEFS].channel;
      wb.value   = y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= chain[COEFS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_channel_ff   <= chain[COEFS].channel;
         rsp_filtered_ff  <= y;
         rsp_saturated_ff <= sat;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_channel_out = rsp_channel_ff;
   assign rsp_filtered    = rsp_filtered_ff;
   assign rsp_saturated   = rsp_saturated_ff;

endmodule

`default_nettype wire

// ----- rtl/iirfo_checker.sv -----
// port-level checker for the multichannel iir filter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "iir_fourth_order_multichannel_assert.svh"

module iirfo_checker import iirfo_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [CH_W-1:0]        rsp_channel_out,
   input wire logic [SAMPLE_BITS-1:0] rsp_filtered,
   input wire logic                   rsp_saturated
);

   localparam logic [SAMPLE_BITS-1:0] OUT_MAX = SAMPLE_BITS'(SAMPLE_MAX);
   localparam logic [SAMPLE_BITS-1:0] OUT_MIN = ~OUT_MAX;

   `IIRFO_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `IIRFO_ASSERT_NOW(a_stall_blocks_req, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `IIRFO_ASSERT_NOW(a_channel_range, clock, reset, rsp_valid, int'(rsp_channel_out) < CHANNELS)
   `IIRFO_ASSERT_NOW(a_sat_at_limit, clock, reset, rsp_valid && rsp_saturated, rsp_filtered == OUT_MAX || rsp_filtered == OUT_MIN)

endmodule

bind iir_fourth_order_multichannel iirfo_checker u_checker (.*);

`default_nettype wire
